@@ design/pvc_pkg.sv @@
// shared types and constants for the plane velocity constraint core
`timescale 1ns / 1ps

package pvc_pkg;

    localparam int DIV_BITS = 63;
    localparam int DIV_LAT  = DIV_BITS + 1;
    localparam int NUM_W    = 128;
    localparam int DEN_W    = 64;

    localparam logic [DIV_BITS-1:0] CAP62 = DIV_BITS'(64'h4000_0000_0000_0000);

    typedef enum logic [1:0] {
        REG_NORMAL_X     = 2'd0,
        REG_NORMAL_Y     = 2'd1,
        REG_NORMAL_Z     = 2'd2,
        REG_PLANE_OFFSET = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        body_mass;
        logic [30:0]        time_step;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               status;
    } rsp_item_t;

    typedef logic [2:0][31:0] vec3_t;

    typedef struct packed {
        logic [63:0] vc;
        logic [63:0] q;
        logic        bad;
        logic        pcneg;
        vec3_t       v;
        vec3_t       n;
    } bpay_t;

    typedef struct packed {
        logic        bad;
        logic [2:0]  neg;
        vec3_t       v;
    } dpay_t;

    function automatic logic [31:0] magn32(input logic [31:0] a);
        magn32 = a[31] ? (32'd0 - a) : a;
    endfunction

    function automatic logic [63:0] sext32(input logic [31:0] a);
        sext32 = {{32{a[31]}}, a};
    endfunction

endpackage

@@ design/pvc_if.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps

interface pvc_req_if;
    import pvc_pkg::*;
    logic      valid;
    logic      ready;
    req_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pvc_rsp_if;
    import pvc_pkg::*;
    logic      valid;
    logic      ready;
    rsp_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/pvc_div.sv @@
// pipelined restoring divider, one quotient bit per stage, saturating quotient
`timescale 1ns / 1ps

module pvc_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [pvc_pkg::NUM_W-1:0]     num,
    input  logic [pvc_pkg::DEN_W-1:0]     den,
    output logic [pvc_pkg::DIV_BITS-1:0]  quo
);
    import pvc_pkg::*;

    logic [DEN_W-1:0]    rem_reg [DIV_LAT];
    logic [DIV_BITS-1:0] low_reg [DIV_LAT];
    logic [DIV_BITS-1:0] q_reg   [DIV_LAT];
    logic [DEN_W-1:0]    den_reg [DIV_LAT];
    logic                ovf_reg [DIV_LAT];

    logic [NUM_W-1:0] thr;

    // quotient above the cap when num >= (cap + 1) * den
    assign thr = (NUM_W'(den) << (DIV_BITS - 1)) + NUM_W'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= (num >= thr);
            rem_reg[0] <= num[DIV_BITS +: DEN_W];
            low_reg[0] <= num[DIV_BITS-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
        end
    end

    for (genvar s = 1; s < DIV_LAT; s++)
    begin : g_stage
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        logic           ge;

        assign t    = {rem_reg[s-1], low_reg[s-1][DIV_BITS-1]};
        assign diff = t - {1'b0, den_reg[s-1]};
        assign ge   = (t >= {1'b0, den_reg[s-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                low_reg[s] <= {low_reg[s-1][DIV_BITS-2:0], 1'b0};
                q_reg[s]   <= {q_reg[s-1][DIV_BITS-2:0], ge};
                den_reg[s] <= den_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    assign quo = ovf_reg[DIV_LAT-1] ? CAP62 : q_reg[DIV_LAT-1];

endmodule

@@ design/plane_velocity_constraint_core.sv @@
// top level: baumgarte plane constraint velocity correction pipeline
`timescale 1ns / 1ps
//
// A request on req carries one body's position, velocity, mass and time
// step; the corrected velocity and a status bit come back on rsp, one
// response per request, in order. Both channels move an item at a clock
// edge with valid and ready high. The constraint normal and offset are
// written on the cfg port (index 0..3: normal_x, normal_y, normal_z,
// plane_offset) while no request is in flight; the core does not check.
// The pipeline is 137 register stages deep: eight arithmetic stages, two
// 64-stage bit-per-cycle dividers (bias by time step, correction by n.n)
// and the output register. A request enters every cycle while the pipeline
// is not stalled, so throughput is then one body per clock.
// Reset (rst_n low) empties the pipeline and loads the normal (0, 1.0, 0)
// and offset 0. When the receiver holds rsp.ready low while a response
// waits, the whole pipeline freezes and req.ready drops; nothing is lost
// or repeated.
//
module plane_velocity_constraint_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    pvc_req_if.sink           req,
    pvc_rsp_if.source         rsp,
    input  logic              cfg_we,
    input  pvc_pkg::reg_idx_t cfg_index,
    input  logic [31:0]       cfg_wdata
);
    import pvc_pkg::*;

    localparam logic [31:0] K_COEF = 32'(((64'd15 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [30:0] DT60   = 31'(((64'd1 << FRAC_BITS) + 64'd30) / 64'd60);
    localparam logic [30:0] ONE_Q  = 31'(64'd1 << FRAC_BITS);

    // configuration
    logic [31:0] nx_reg, ny_reg, nz_reg, d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0;
            ny_reg <= {1'b0, ONE_Q};
            nz_reg <= '0;
            d_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NORMAL_X:     nx_reg <= cfg_wdata;
                REG_NORMAL_Y:     ny_reg <= cfg_wdata;
                REG_NORMAL_Z:     nz_reg <= cfg_wdata;
                REG_PLANE_OFFSET: d_reg  <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // valid bits and stall control
    logic                en;
    logic [8:1]          vld_reg;
    logic [DIV_LAT-1:0]  bvld_reg;
    logic [DIV_LAT-1:0]  dvld_reg;
    logic                out_vld_reg;

    assign en        = !out_vld_reg || rsp.ready;
    assign req.ready = en;
    assign rsp.valid = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            bvld_reg    <= '0;
            dvld_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[7:6], bvld_reg[DIV_LAT-1], vld_reg[4:1], req.valid};
            bvld_reg    <= {bvld_reg[DIV_LAT-2:0], vld_reg[5]};
            dvld_reg    <= {dvld_reg[DIV_LAT-2:0], vld_reg[8]};
            out_vld_reg <= dvld_reg[DIV_LAT-1];
        end
    end

    // stage 1: capture
    vec3_t       n1_reg, p1_reg, v1_reg;
    logic [31:0] d1_reg;
    logic        mz1_reg;
    logic [30:0] dt1_reg;

    // stage 2: products
    logic [2:0][63:0] qp2_reg, qv2_reg, nn2_reg;
    logic [63:0]      d2_reg;
    logic             mz2_reg;
    logic [30:0]      dt2_reg;
    vec3_t            n2_reg, v2_reg;

    // stage 3: sums
    logic [63:0] pc3_reg;
    logic [30:0] dt3_reg;
    bpay_t       bp3_reg;

    // stage 4: bias numerator partial products
    logic [63:0] pkl4_reg, pkh4_reg;
    logic [30:0] dt4_reg;
    bpay_t       bp4_reg;

    // stage 5: bias numerator
    logic [NUM_W-1:0] bnum5_reg;
    logic [30:0]      dt5_reg;
    bpay_t            bp5_reg;

    bpay_t               bpd_reg [DIV_LAT];
    logic [DIV_BITS-1:0] bquo;

    // stage 6: constraint error
    logic [DIV_BITS-1:0] emag6_reg;
    logic                eneg6_reg;
    bpay_t               bp6_reg;

    // stage 7: correction partial products
    logic [2:0][63:0] pl7_reg, ph7_reg;
    logic [63:0]      q7_reg;
    dpay_t            dp7_reg;

    // stage 8: correction numerators
    logic [2:0][NUM_W-1:0] dnum8_reg;
    logic [63:0]           q8_reg;
    dpay_t                 dp8_reg;

    dpay_t                       dpd_reg [DIV_LAT];
    logic [2:0][DIV_BITS-1:0]    dquo;

    rsp_item_t out_reg;

    // combinational next values
    logic [2:0][63:0] qp2_next, qv2_next, nn2_next;
    logic [63:0]      pc3_next;
    logic [63:0]      pcmag;
    logic [63:0]      bias;
    logic [63:0]      e_next;
    logic [63:0]      emag_full;
    logic [2:0][63:0] pl7_next, ph7_next;
    logic [2:0]       neg7_next;
    logic [2:0][31:0] nv_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [63:0] pm;
            logic [63:0] vm;
            pm = 64'(magn32(n1_reg[i])) * 64'(magn32(p1_reg[i]));
            vm = 64'(magn32(n1_reg[i])) * 64'(magn32(v1_reg[i]));
            pm = pm >> FRAC_BITS;
            vm = vm >> FRAC_BITS;
            qp2_next[i] = (n1_reg[i][31] ^ p1_reg[i][31]) ? (64'd0 - pm) : pm;
            qv2_next[i] = (n1_reg[i][31] ^ v1_reg[i][31]) ? (64'd0 - vm) : vm;
            nn2_next[i] = 64'(magn32(n1_reg[i])) * 64'(magn32(n1_reg[i]));
        end
    end

    assign pc3_next = qp2_reg[0] + qp2_reg[1] + qp2_reg[2] - d2_reg;
    assign pcmag    = pc3_reg[63] ? (64'd0 - pc3_reg) : pc3_reg;

    assign bias      = bpd_reg[DIV_LAT-1].pcneg ? (64'd0 - {1'b0, bquo}) : {1'b0, bquo};
    assign e_next    = 64'd0 - bpd_reg[DIV_LAT-1].vc - bias;
    assign emag_full = e_next[63] ? (64'd0 - e_next) : e_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pl7_next[i]  = 64'(magn32(bp6_reg.n[i])) * 64'(emag6_reg[31:0]);
            ph7_next[i]  = 64'(magn32(bp6_reg.n[i])) * 64'(emag6_reg[DIV_BITS-1:32]);
            neg7_next[i] = bp6_reg.n[i][31] ^ eneg6_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [63:0] dm;
            logic [63:0] sum;
            dm  = {1'b0, dquo[i]};
            sum = sext32(dpd_reg[DIV_LAT-1].v[i])
                + (dpd_reg[DIV_LAT-1].neg[i] ? (64'd0 - dm) : dm);
            if (sum[63:31] != {33{sum[63]}})
                nv_next[i] = sum[63] ? 32'h8000_0000 : 32'h7fff_ffff;
            else
                nv_next[i] = sum[31:0];
            if (dpd_reg[DIV_LAT-1].bad)
                nv_next[i] = dpd_reg[DIV_LAT-1].v[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg  <= {nz_reg, ny_reg, nx_reg};
            p1_reg  <= {req.data.pos_z, req.data.pos_y, req.data.pos_x};
            v1_reg  <= {req.data.vel_z, req.data.vel_y, req.data.vel_x};
            d1_reg  <= d_reg;
            mz1_reg <= (req.data.body_mass == '0);
            dt1_reg <= (req.data.time_step == '0) ? DT60 : req.data.time_step;

            qp2_reg <= qp2_next;
            qv2_reg <= qv2_next;
            nn2_reg <= nn2_next;
            d2_reg  <= sext32(d1_reg);
            mz2_reg <= mz1_reg;
            dt2_reg <= dt1_reg;
            n2_reg  <= n1_reg;
            v2_reg  <= v1_reg;

            pc3_reg       <= pc3_next;
            dt3_reg       <= dt2_reg;
            bp3_reg.vc    <= qv2_reg[0] + qv2_reg[1] + qv2_reg[2];
            bp3_reg.q     <= nn2_reg[0] + nn2_reg[1] + nn2_reg[2];
            bp3_reg.bad   <= mz2_reg || ((nn2_reg[0] | nn2_reg[1] | nn2_reg[2]) == '0);
            bp3_reg.pcneg <= pc3_next[63];
            bp3_reg.v     <= v2_reg;
            bp3_reg.n     <= n2_reg;

            pkl4_reg <= 64'(pcmag[31:0]) * 64'(K_COEF);
            pkh4_reg <= 64'(pcmag[63:32]) * 64'(K_COEF);
            dt4_reg  <= dt3_reg;
            bp4_reg  <= bp3_reg;

            bnum5_reg <= (NUM_W'(pkh4_reg) << 32) + NUM_W'(pkl4_reg);
            dt5_reg   <= dt4_reg;
            bp5_reg   <= bp4_reg;

            bpd_reg[0] <= bp5_reg;
            for (int s = 1; s < DIV_LAT; s++)
                bpd_reg[s] <= bpd_reg[s-1];

            emag6_reg <= emag_full[DIV_BITS-1:0];
            eneg6_reg <= e_next[63];
            bp6_reg   <= bpd_reg[DIV_LAT-1];

            pl7_reg     <= pl7_next;
            ph7_reg     <= ph7_next;
            q7_reg      <= bp6_reg.q;
            dp7_reg.bad <= bp6_reg.bad;
            dp7_reg.neg <= neg7_next;
            dp7_reg.v   <= bp6_reg.v;

            for (int i = 0; i < 3; i++)
                dnum8_reg[i] <= ((NUM_W'(ph7_reg[i]) << 32) + NUM_W'(pl7_reg[i]))
                                << FRAC_BITS;
            q8_reg  <= q7_reg;
            dp8_reg <= dp7_reg;

            dpd_reg[0] <= dp8_reg;
            for (int s = 1; s < DIV_LAT; s++)
                dpd_reg[s] <= dpd_reg[s-1];

            out_reg.new_vel_x <= nv_next[0];
            out_reg.new_vel_y <= nv_next[1];
            out_reg.new_vel_z <= nv_next[2];
            out_reg.status    <= dpd_reg[DIV_LAT-1].bad;
        end
    end

    assign rsp.data = out_reg;

    // bias magnitude = |n.p - d| * k / dt
    pvc_div u_bias_div (
        .clk (clk),
        .en  (en),
        .num (bnum5_reg),
        .den (DEN_W'(dt5_reg)),
        .quo (bquo)
    );

    // correction magnitude = |n_i| * |e| * S / (n.n)
    for (genvar i = 0; i < 3; i++)
    begin : g_corr
        pvc_div u_corr_div (
            .clk (clk),
            .en  (en),
            .num (dnum8_reg[i]),
            .den (q8_reg),
            .quo (dquo[i])
        );
    end

    // a stall freezes every valid bit in the pipeline
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(vld_reg) && $stable(bvld_reg) && $stable(dvld_reg)))
        else $error("pipeline moved during stall");

    // an accepted request occupies the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> vld_reg[1])
        else $error("accepted request lost");

    // the bias divider never returns more than the cap
    a_bias_cap: assert property (@(posedge clk) disable iff (!rst_n)
        bvld_reg[DIV_LAT-1] |-> (bquo <= CAP62))
        else $error("bias quotient above cap");

endmodule

@@ tb/plane_velocity_constraint_core_tb.sv @@
// self-checking testbench for the plane velocity constraint core
`timescale 1ns / 1ps

module plane_velocity_constraint_core_tb;
    import pvc_pkg::*;

    localparam int        LATENCY     = 137;
    localparam int        CYCLE_LIMIT = 3000000;
    localparam int        PHASE_ITEMS = 210;
    localparam int        NUM_PHASES  = 9;
    localparam bit [63:0] SPEED_CAP   = 64'h4000_0000_0000_0000;
    localparam bit [63:0] BAUM_K      = 64'd9830;
    localparam bit [30:0] STEP_60HZ   = 31'd1092;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    reg_idx_t    cfg_index;
    logic [31:0] cfg_wdata;

    pvc_req_if req ();
    pvc_rsp_if rsp ();

    plane_velocity_constraint_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    logic signed [31:0] nrm_x, nrm_y, nrm_z, offset_d;

    req_item_t  body_q[$];
    rsp_item_t  vel_q[$];
    bit         req_fire;
    bit         no_gaps;
    int         req_gap;
    int         rsp_stall;
    int         cycles;
    int         errors;
    int         responses;
    int         flagged;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic bit [63:0] mag64(longint x);
        return x < 0 ? 64'd0 - 64'(x) : 64'(x);
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        bit [63:0] m;
        m = (mag64(a) * mag64(b)) >> 16;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic bit [63:0] capped_div(bit [127:0] num, bit [63:0] den);
        bit [127:0] quo;
        quo = num / {64'd0, den};
        return (quo > {64'd0, SPEED_CAP}) ? SPEED_CAP : quo[63:0];
    endfunction

    function automatic rsp_item_t corrected_velocity(req_item_t r);
        longint     n[3];
        longint     p[3];
        longint     v[3];
        longint     pc, vc, bias, e, s;
        longint     res[3];
        bit [63:0]  q, bmag, emag, dmag;
        bit [30:0]  dt;
        bit [127:0] w;
        rsp_item_t  o;
        n[0] = nrm_x;    n[1] = nrm_y;    n[2] = nrm_z;
        p[0] = r.pos_x;  p[1] = r.pos_y;  p[2] = r.pos_z;
        v[0] = r.vel_x;  v[1] = r.vel_y;  v[2] = r.vel_z;
        q = 0;
        for (int i = 0; i < 3; i++)
            q += mag64(n[i]) * mag64(n[i]);
        if (r.body_mass == 0 || q == 0)
        begin
            o.new_vel_x = r.vel_x;
            o.new_vel_y = r.vel_y;
            o.new_vel_z = r.vel_z;
            o.status    = 1'b1;
            return o;
        end
        dt = (r.time_step == 0) ? STEP_60HZ : r.time_step;
        pc = fix_mul(n[0], p[0]) + fix_mul(n[1], p[1]) + fix_mul(n[2], p[2]) - longint'(offset_d);
        vc = fix_mul(n[0], v[0]) + fix_mul(n[1], v[1]) + fix_mul(n[2], v[2]);
        bmag = capped_div({64'd0, mag64(pc)} * {64'd0, BAUM_K}, {33'd0, dt});
        bias = (pc < 0) ? -longint'(bmag) : longint'(bmag);
        e = -vc - bias;
        emag = mag64(e);
        for (int i = 0; i < 3; i++)
        begin
            w = ({64'd0, mag64(n[i])} * {64'd0, emag}) << 16;
            dmag = capped_div(w, q);
            s = v[i] + (((n[i] < 0) != (e < 0)) ? -longint'(dmag) : longint'(dmag));
            if (s > 64'sd2147483647)
                s = 64'sd2147483647;
            else if (s < -64'sd2147483648)
                s = -64'sd2147483648;
            res[i] = s;
        end
        o.new_vel_x = res[0][31:0];
        o.new_vel_y = res[1][31:0];
        o.new_vel_z = res[2][31:0];
        o.status    = 1'b0;
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // checker: requests predicted on acceptance, responses compared in order
    always @(posedge clk)
    begin
        rsp_item_t want;
        rsp_item_t got;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** plane_velocity_constraint_core: FAILED **");
            $finish;
        end
        req_fire = rst_n && req.valid && req.ready;
        if (req_fire)
            vel_q.push_back(corrected_velocity(req.data));
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = rsp.data;
            responses++;
            if (got.status)
                flagged++;
            if (vel_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response %h", $time, got);
            end
            else
            begin
                want = vel_q.pop_front();
                if (got.new_vel_x !== want.new_vel_x || got.new_vel_y !== want.new_vel_y ||
                    got.new_vel_z !== want.new_vel_z || got.status !== want.status)
                begin
                    errors++;
                    if (errors <= 20)
                        $display("%0t: mismatch expected x=%h y=%h z=%h st=%b got x=%h y=%h z=%h st=%b",
                                 $time, want.new_vel_x, want.new_vel_y, want.new_vel_z,
                                 want.status, got.new_vel_x, got.new_vel_y, got.new_vel_z,
                                 got.status);
                end
            end
        end
    end

    // request driver and response stall generator
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_fire || !req.valid)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req.valid <= 1'b0;
                end
                else if (body_q.size() > 0)
                begin
                    req.data  <= body_q.pop_front();
                    req.valid <= 1'b1;
                    req_gap = pick_gap();
                end
                else
                    req.valid <= 1'b0;
            end
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                rsp_stall = pick_gap();
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                             logic [31:0] d);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_PLANE_OFFSET, d);
        nrm_x = nx;
        nrm_y = ny;
        nrm_z = nz;
        offset_d = d;
    endtask

    task automatic drain();
        while (body_q.size() > 0 || vel_q.size() > 0 || req.valid)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom;
        if (r < 8)
            return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        return r == 8 ? 32'h7fff_ffff : 32'h8000_0000;
    endfunction

    task automatic push_random(int count);
        req_item_t b;
        int r;
        for (int k = 0; k < count; k++)
        begin
            b.pos_x = pick_word();
            b.pos_y = pick_word();
            b.pos_z = pick_word();
            b.vel_x = pick_word();
            b.vel_y = pick_word();
            b.vel_z = pick_word();
            r = $urandom_range(0, 19);
            b.body_mass = (r == 0) ? 31'd0 : (r < 10 ? 31'($urandom) : 31'($urandom_range(1, 1 << 20)));
            r = $urandom_range(0, 19);
            b.time_step = (r < 2) ? 31'd0 : (r < 8 ? 31'($urandom) :
                          31'($urandom_range(1, 1 << 17)));
            body_q.push_back(b);
        end
    endtask

    task automatic push_body(logic [31:0] p, logic [31:0] v, logic [30:0] m, logic [30:0] dt);
        req_item_t b;
        b.pos_x = p; b.pos_y = p; b.pos_z = p;
        b.vel_x = v; b.vel_y = v; b.vel_z = v;
        b.body_mass = m;
        b.time_step = dt;
        body_q.push_back(b);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_NORMAL_X;
        cfg_wdata  = '0;
        req.valid  = 1'b0;
        req.data   = '0;
        rsp.ready  = 1'b0;
        nrm_x      = 32'sd0;
        nrm_y      = 32'sd65536;
        nrm_z      = 32'sd0;
        offset_d   = 32'sd0;
        no_gaps    = 1'b0;
        req_gap    = 0;
        rsp_stall  = 0;
        cycles     = 0;
        errors     = 0;
        responses  = 0;
        flagged    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed bodies against the reset plane
        push_body(32'h0001_0000, 32'h0000_0000, 31'h0001_0000, 31'h0000_1111);
        push_body(32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
        push_body(32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff, 31'h7fff_ffff);
        push_body(32'h7fff_ffff, 32'h8000_0000, 31'h0001_0000, 31'd1);
        push_body(32'h8000_0000, 32'h7fff_ffff, 31'h0001_0000, 31'd1);
        push_body(32'hffff_0000, 32'h0002_0000, 31'd0, 31'h0000_1000);
        push_body(32'hffff_0000, 32'h0002_0000, 31'h0001_0000, 31'd0);
        push_body(32'h0000_0000, 32'hffff_ffff, 31'd1, 31'd0);
        push_body(32'h1234_5678, 32'h8765_4321, 31'h5555_5555, 31'h2aaa_aaaa);
        push_body(32'hffff_ffff, 32'h0000_0001, 31'h7fff_ffff, 31'd1);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            repeat (LATENCY + 10) @(posedge clk);
            case (ph)
                0: set_plane(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
                1: set_plane(32'hfffe_0000, 32'h0001_0000, 32'h0000_0000, 32'h0003_0000);
                2: set_plane(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0005_0000);
                3: set_plane(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
                4: set_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                5: set_plane(32'h0000_0001, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000);
                default: set_plane(pick_word(), pick_word(), pick_word(), pick_word());
            endcase
            no_gaps = (ph == 1 || ph == 6);
            push_random(PHASE_ITEMS / 2);
            drain();
            push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            drain();
        end

        repeat (LATENCY + 20) @(posedge clk);
        $display("run covered %0d responses (%0d flagged) over %0d plane settings, %0d cycles",
                 responses, flagged, NUM_PHASES + 1, cycles);
        if (errors == 0 && vel_q.size() == 0)
            $display("** plane_velocity_constraint_core: PASSED **");
        else
            $display("** plane_velocity_constraint_core: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
design/pvc_pkg.sv
design/pvc_if.sv
design/pvc_div.sv
design/plane_velocity_constraint_core.sv
tb/plane_velocity_constraint_core_tb.sv
